@@ src/mpcc_pkg.sv @@
`timescale 1ns / 1ps
package mpcc_pkg;

  // path store geometry
  localparam int AGENTS    = 16;
  localparam int MAX_STEPS = 64;
  localparam int AGENT_W   = 4;
  localparam int STEP_W    = 6;
  localparam int LOC_W     = 16;
  localparam int LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int ADDR_W    = AGENT_W + STEP_W;
  localparam int STORE_DEPTH = AGENTS * MAX_STEPS;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified path element
  typedef struct packed {
    logic [AGENT_W-1:0] agent;
    logic [STEP_W-1:0]  step;
    logic [LOC_W-1:0]   location;
    logic               final_item;
    logic               in_range;
  } item_t;

  // sweep sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LA    = 6'b000010,
    S_LB    = 6'b000100,
    S_SETUP = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

@@ src/mpcc_ram.sv @@
`timescale 1ns / 1ps
module mpcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/mpcc_front.sv @@
`timescale 1ns / 1ps
module mpcc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            agent,
  input  logic [5:0]            step_index,
  input  logic [15:0]           location,
  input  logic                  final_item,
  output logic                  q_valid,
  input  logic                  q_ready,
  output mpcc_pkg::item_t       q_item
);
  import mpcc_pkg::*;

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  item_t             new_item;

  // classify the incoming item
  always_comb begin
    new_item.agent      = agent;
    new_item.step       = step_index;
    new_item.location   = location;
    new_item.final_item = final_item;
    new_item.in_range   = ({1'b0, agent} < (AGENT_W + 1)'(AGENTS)) &&
                          ({1'b0, step_index} < (STEP_W + 1)'(MAX_STEPS));
  end

  assign in_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/mpcc_back.sv @@
`timescale 1ns / 1ps
module mpcc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_hold,
  input  logic            q_valid,
  output logic            q_ready,
  input  mpcc_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            collision
);
  import mpcc_pkg::*;

  state_t               state;
  logic                 hold;
  logic [LEN_W-1:0]     len [AGENTS];
  logic [AGENT_W-1:0]   len_idx;
  logic [LEN_W-1:0]     len_rd;
  logic [LEN_W-1:0]     step_len;
  logic [AGENT_W-1:0]   a;
  logic [AGENT_W-1:0]   b;
  logic [LEN_W-1:0]     la;
  logic [LEN_W-1:0]     lb;
  logic [LEN_W-1:0]     common;
  logic [LEN_W-1:0]     common_next;
  logic [LEN_W-1:0]     limit;
  logic                 longer_is_a;
  logic [LEN_W-1:0]     iss;
  logic                 iss_valid;
  logic                 d_valid;
  logic [LEN_W-1:0]     d_ts;
  logic [LOC_W-1:0]     p;
  logic [LOC_W-1:0]     q;
  logic [LOC_W-1:0]     prev_p;
  logic [LOC_W-1:0]     prev_q;
  logic [LOC_W-1:0]     held;
  logic                 hit;
  logic                 pair_done;
  logic                 last_pair;
  logic                 pop;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr_a;
  logic [ADDR_W-1:0]    rd_addr_b;

  // two mirrored copies of the path store, one per agent of the pair
  assign wr_en     = pop && q_item.in_range;
  assign wr_addr   = {q_item.agent, q_item.step};
  assign rd_addr_a = {a, iss[STEP_W-1:0]};
  assign rd_addr_b = {b, iss[STEP_W-1:0]};

  mpcc_ram #(.WIDTH(LOC_W), .DEPTH(STORE_DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (q_item.location),
    .rd_addr (rd_addr_a),
    .rd_data (p)
  );

  mpcc_ram #(.WIDTH(LOC_W), .DEPTH(STORE_DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (q_item.location),
    .rd_addr (rd_addr_b),
    .rd_data (q)
  );

  assign q_ready = (state == S_IDLE);
  assign pop     = q_valid && q_ready;

  // single read of the length table
  always_comb begin
    unique case (state)
      S_IDLE:  len_idx = q_item.agent;
      S_LA:    len_idx = a;
      default: len_idx = b;
    endcase
  end
  assign len_rd   = len[len_idx];
  assign step_len = LEN_W'(q_item.step) + 1'b1;

  // pair setup values
  assign common_next = (la < lb) ? la : lb;
  assign iss_valid   = (state == S_SWEEP) && (iss < limit);
  assign last_pair   = (a == AGENT_W'(AGENTS - 2)) && (b == AGENT_W'(AGENTS - 1));
  assign pair_done   = ((state == S_SETUP) && (common_next == '0)) ||
                       ((state == S_SWEEP) && !iss_valid && !d_valid);

  // endpoint hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (cfg_we) begin
      hold <= cfg_hold;
    end
  end

  // path lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AGENTS; i++) begin
        len[i] <= '0;
      end
    end else if (state == S_DONE && !out_valid) begin
      for (int i = 0; i < AGENTS; i++) begin
        len[i] <= '0;
      end
    end else if (wr_en && (len_rd < step_len)) begin
      len[q_item.agent] <= step_len;
    end
  end

  // sequencer over agent pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a     <= '0;
      b     <= '0;
      iss   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop && q_item.final_item) begin
            a     <= '0;
            b     <= AGENT_W'(1);
            state <= S_LA;
          end
        end
        S_LA: begin
          state <= S_LB;
        end
        S_LB: begin
          state <= S_SETUP;
        end
        S_SETUP: begin
          iss   <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (iss_valid) begin
            iss <= iss + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // advance to the next pair or finish
      if (pair_done) begin
        if (hit || last_pair) begin
          state <= S_DONE;
        end else if (b == AGENT_W'(AGENTS - 1)) begin
          a     <= a + 1'b1;
          b     <= a + AGENT_W'(2);
          state <= S_LA;
        end else begin
          b     <= b + 1'b1;
          state <= S_LB;
        end
      end
    end
  end

  // per-pair length registers
  always_ff @(posedge clk) begin
    if (state == S_LA) begin
      la <= len_rd;
    end
    if (state == S_LB) begin
      lb <= len_rd;
    end
    if (state == S_SETUP) begin
      common      <= common_next;
      longer_is_a <= (la > lb);
      if (hold && (la != lb)) begin
        limit <= (la > lb) ? la : lb;
      end else begin
        limit <= common_next;
      end
    end
  end

  // read data tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= iss_valid;
    end
    d_ts <= iss;
  end

  // vertex, swap and held endpoint compare
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (pop && q_item.final_item) begin
      hit <= 1'b0;
    end else if (d_valid) begin
      if (d_ts < common) begin
        if (p == q) begin
          hit <= 1'b1;
        end
        if ((d_ts != '0) && (prev_p == q) && (prev_q == p)) begin
          hit <= 1'b1;
        end
      end else if ((longer_is_a ? p : q) == held) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid) begin
      prev_p <= p;
      prev_q <= q;
      if (d_ts == common - 1'b1) begin
        held <= longer_is_a ? q : p;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && !out_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && !out_valid) begin
      collision <= hit;
    end
  end

endmodule

@@ src/multi_path_conflict_checker.sv @@
`timescale 1ns / 1ps
// Multi-agent path conflict checker.
// Input channel (in_valid/in_ready): one path element per item, tagged with
// agent and step_index; final_item marks the last element of a load and
// starts the pairwise check. Non-final items give no result.
// Output channel (out_valid/out_ready): one collision flag per final item.
// Config channel (cfg_valid/cfg_ready, always ready): hold_last.
// Throughput: a 4-entry queue decouples the input from the store writer, so
// path elements load one per cycle while the back end is idle. The final
// item starts a sweep over all agent pairs: per pair a lookup of one or
// both lengths and a setup step, then the swept steps go through the path
// store read port; a sweep stops at the first pair that collides. Items
// keep queueing during the sweep until the queue fills. When the flag is
// registered the path lengths are cleared.
// Reset clears the queue, the lengths and hold_last; the path store
// is not cleared. A stalled receiver holds the flag in the output register;
// loading goes on until the next sweep ends, then that result waits for
// the register and the input stops once the queue fills.
module multi_path_conflict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  agent,
  input  logic [5:0]  step_index,
  input  logic [15:0] location,
  input  logic        final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        collision,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        hold_last
);
  import mpcc_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign cfg_ready = 1'b1;

  // accept and classify
  mpcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .agent      (agent),
    .step_index (step_index),
    .location   (location),
    .final_item (final_item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  // store paths and sweep pairs
  mpcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_hold  (hold_last),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .collision (collision)
  );

endmodule

@@ sim/tb_multi_path_conflict_checker.sv @@
`timescale 1ns / 1ps
module tb_multi_path_conflict_checker;
  import mpcc_pkg::*;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int SETTLE_WAIT  = 20;
  localparam int RANDOM_ITEMS = 1300;

  // one path element, or a register write when cfg is set
  typedef struct packed {
    logic               cfg;
    logic               hold;
    logic [AGENT_W-1:0] agent;
    logic [STEP_W-1:0]  step;
    logic [LOC_W-1:0]   loc;
    logic               fin;
    logic               typed;
    logic               want;
  } row_t;

  // how closely the locations of one load are packed
  typedef enum int {SPREAD_TIGHT, SPREAD_LOOSE, SPREAD_WIDE} spread_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         agent;
  logic [5:0]         step_index;
  logic [15:0]        location;
  logic               final_item;
  logic               out_valid;
  logic               out_ready;
  logic               collision;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               hold_last;

  // predictor state
  logic [LOC_W-1:0]   path_mem [AGENTS][MAX_STEPS];
  int                 path_len [AGENTS];
  logic               hold_cfg;
  bit                 collision_due [$];
  bit                 want_bit;
  logic               cur_typed;
  logic               cur_want;

  // generator state
  bit                 gen_seen [AGENTS][MAX_STEPS];
  int                 gen_len [AGENTS];
  row_t               load_q [$];

  int                 err_count;
  int                 accepted;
  int                 cycle_count;
  bit                 calm;

  // directed items: cfg, hold, agent, step, location, final, typed, expected
  row_t dir_rows [23] = '{
    '{1'b0, 1'b0, 4'd0,  6'd0, 16'd0,     1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b0, 4'd0,  6'd0, 16'hFFFF,  1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd15, 6'd0, 16'hFFFF,  1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 4'd1,  6'd0, 16'd100,   1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd1,  6'd1, 16'd200,   1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd2,  6'd0, 16'd200,   1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd2,  6'd1, 16'd100,   1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 4'd3,  6'd0, 16'd1,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd3,  6'd1, 16'd2,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd3,  6'd0, 16'd3,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd4,  6'd0, 16'd4,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd4,  6'd1, 16'd5,     1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd5,  6'd0, 16'd7,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd6,  6'd0, 16'd8,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd6,  6'd1, 16'd7,     1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b1, 4'd0,  6'd0, 16'd0,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd5,  6'd0, 16'd7,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd6,  6'd0, 16'd8,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd6,  6'd1, 16'd7,     1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 4'd7,  6'd0, 16'd0,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd7,  6'd1, 16'd0,     1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 4'd7,  6'd2, 16'd0,     1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b0, 4'd0,  6'd0, 16'd0,     1'b0, 1'b0, 1'b0}
  };

  multi_path_conflict_checker uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .agent          (agent),
    .step_index     (step_index),
    .location       (location),
    .final_item     (final_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .collision      (collision),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .hold_last      (hold_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // conflict test of one agent pair
  function automatic bit pair_hits(int a, int b);
    int               la;
    int               lb;
    int               common;
    int               short_ag;
    int               long_ag;
    int               t;
    logic [LOC_W-1:0] held;
    la = path_len[a];
    lb = path_len[b];
    common = (la < lb) ? la : lb;
    for (t = 0; t < common; t++) begin
      if (path_mem[a][t] == path_mem[b][t]) return 1'b1;
      if (t + 1 < common && path_mem[a][t] == path_mem[b][t+1] &&
          path_mem[b][t] == path_mem[a][t+1]) return 1'b1;
    end
    // a finished agent parks on its last location
    if (hold_cfg && la != lb) begin
      short_ag = (la < lb) ? a : b;
      long_ag  = (la < lb) ? b : a;
      if (path_len[short_ag] == 0) return 1'b0;
      held = path_mem[short_ag][path_len[short_ag]-1];
      for (t = path_len[short_ag]; t < path_len[long_ag]; t++) begin
        if (path_mem[long_ag][t] == held) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // sweep over every agent pair
  function automatic bit sweep_paths();
    for (int a = 0; a < AGENTS; a++) begin
      for (int b = a + 1; b < AGENTS; b++) begin
        if (pair_hits(a, b)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // predictor and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        hold_cfg = hold_last;
      end
      if (in_valid && in_ready) begin
        accepted++;
        path_mem[agent][step_index] = location;
        if (path_len[agent] < int'(step_index) + 1) begin
          path_len[agent] = int'(step_index) + 1;
        end
        if (final_item) begin
          want_bit = sweep_paths();
          collision_due.insert(collision_due.size(), cur_typed ? cur_want : want_bit);
          path_len = '{default: 0};
        end
      end
      if (out_valid && out_ready) begin
        if (collision_due.size() == 0) begin
          $error("collision result with no item waiting, actual %0b", collision);
          err_count++;
        end else begin
          want_bit = collision_due.pop_front();
          if (collision !== want_bit) begin
            $error("collision mismatch: expected %0b, actual %0b", want_bit, collision);
            err_count++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // queue one element of the load and note what it writes
  function automatic void stage(int ag, int st, logic [LOC_W-1:0] lc, logic fin);
    row_t r;
    r = '0;
    r.agent = AGENT_W'(ag);
    r.step  = STEP_W'(st);
    r.loc   = lc;
    r.fin   = fin;
    load_q.insert(load_q.size(), r);
    gen_seen[ag][st] = 1'b1;
    if (gen_len[ag] < st + 1) gen_len[ag] = st + 1;
  endfunction

  // back-fill steps never written, then end the load with its final item
  function automatic void close_load(int ag, int st, logic [LOC_W-1:0] lc);
    gen_seen[ag][st] = 1'b1;
    if (gen_len[ag] < st + 1) gen_len[ag] = st + 1;
    for (int a = 0; a < AGENTS; a++) begin
      for (int s = 0; s < gen_len[a]; s++) begin
        if (!gen_seen[a][s]) stage(a, s, LOC_W'($urandom), 1'b0);
      end
    end
    stage(ag, st, lc, 1'b1);
    gen_len = '{default: 0};
  endfunction

  // short steps mostly, the full range now and then
  function automatic int noise_step();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_STEPS - 1)
                                       : $urandom_range(0, 5);
  endfunction

  // well-formed load: whole paths for 2 to 4 agents, now and then 6 or more
  function automatic void build_paths();
    int               ids [$];
    int               lens [AGENTS];
    logic [LOC_W-1:0] paths [AGENTS][MAX_STEPS];
    row_t             elems [$];
    row_t             r;
    logic [LOC_W-1:0] base;
    spread_t          spread;
    int               nag;
    int               ag;
    int               t;
    int               shortest;
    bit               down;
    for (int i = 0; i < AGENTS; i++) ids.insert(ids.size(), i);
    ids.shuffle();
    nag = ($urandom_range(0, 9) == 0) ? $urandom_range(6, AGENTS) : $urandom_range(2, 4);
    spread = spread_t'($urandom_range(0, 2));
    base = LOC_W'($urandom);
    for (int k = 0; k < nag; k++) begin
      ag = ids[k];
      lens[k] = ($urandom_range(0, 14) == 0) ? $urandom_range(20, MAX_STEPS)
                                             : $urandom_range(1, 6);
      for (int s = 0; s < lens[k]; s++) begin
        case (spread)
          SPREAD_TIGHT: paths[ag][s] = base + LOC_W'($urandom_range(0, 3));
          SPREAD_LOOSE: paths[ag][s] = base + LOC_W'($urandom_range(0, 11));
          default:      paths[ag][s] = LOC_W'($urandom);
        endcase
      end
    end
    // plant a swap between the first two agents now and then
    shortest = (lens[0] < lens[1]) ? lens[0] : lens[1];
    if ($urandom_range(0, 3) == 0 && shortest >= 2) begin
      t = $urandom_range(0, shortest - 2);
      paths[ids[1]][t]   = paths[ids[0]][t+1];
      paths[ids[1]][t+1] = paths[ids[0]][t];
    end
    for (int k = 0; k < nag; k++) begin
      ag = ids[k];
      down = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < lens[k]; s++) begin
        r = '0;
        r.agent = AGENT_W'(ag);
        r.step  = STEP_W'(down ? lens[k] - 1 - s : s);
        r.loc   = paths[ag][r.step];
        elems.insert(elems.size(), r);
      end
    end
    if ($urandom_range(0, 2) == 0) elems.shuffle();
    r = elems.pop_back();
    foreach (elems[i]) stage(elems[i].agent, elems[i].step, elems[i].loc, 1'b0);
    close_load(r.agent, r.step, r.loc);
  endfunction

  // scattered elements with random tags
  function automatic void build_noise();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) begin
      stage($urandom_range(0, AGENTS - 1), noise_step(), LOC_W'($urandom), 1'b0);
    end
    close_load($urandom_range(0, AGENTS - 1), noise_step(), LOC_W'($urandom));
  endfunction

  // drive one item, starting and ending at a falling edge
  task automatic send_item(row_t r);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    agent      = r.agent;
    step_index = r.step;
    location   = r.loc;
    final_item = r.fin;
    cur_typed  = r.typed;
    cur_want   = r.want;
    gen_seen[r.agent][r.step] = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (collision_due.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_hold(logic v);
    settle();
    cfg_valid = 1'b1;
    hold_last = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stimulus
  initial begin
    int phase;
    int nloads;
    rst            = 1'b1;
    in_valid       = 1'b0;
    agent          = '0;
    step_index     = '0;
    location       = '0;
    final_item     = 1'b0;
    cfg_valid      = 1'b0;
    hold_last      = 1'b0;
    cur_typed      = 1'b0;
    cur_want       = 1'b0;
    hold_cfg       = 1'b0;
    err_count      = 0;
    accepted       = 0;
    cycle_count    = 0;
    calm           = 1'b0;
    path_len       = '{default: 0};
    gen_len        = '{default: 0};
    for (int a = 0; a < AGENTS; a++) begin
      for (int s = 0; s < MAX_STEPS; s++) path_mem[a][s] = '0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_hold(dir_rows[i].hold);
      end else begin
        send_item(dir_rows[i]);
      end
    end

    // random loads in phases, one register setting per phase
    phase = 0;
    while (accepted < RANDOM_ITEMS + $size(dir_rows)) begin
      write_hold(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      calm = (phase == 3 || phase == 4);
      nloads = $urandom_range(5, 15);
      repeat (nloads) begin
        if (accepted >= RANDOM_ITEMS + $size(dir_rows)) break;
        if ($urandom_range(0, 99) < 85) begin
          build_paths();
        end else begin
          build_noise();
        end
        foreach (load_q[i]) send_item(load_q[i]);
        load_q.delete();
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mpcc_pkg.sv
src/mpcc_ram.sv
src/mpcc_front.sv
src/mpcc_back.sv
src/multi_path_conflict_checker.sv
sim/tb_multi_path_conflict_checker.sv
